// File: rtl/core/lavm_pkg.sv
// Package: shared widths, payload types and helpers for the look-at view matrix core.
package lavm_pkg;

  localparam int UNIT_FRAC_BITS = 14;
  localparam int CW   = 32;
  localparam int UW   = UNIT_FRAC_BITS + 2;
  localparam int NIW  = CW + 1 + UW;
  localparam int NB   = 30;
  localparam int CNTW = $clog2(NIW + 1);
  localparam int SQW  = 2 * NB + 4;
  localparam int SQ_STEPS = NB + 1;
  localparam int LENW = NB + 1;
  localparam int QW   = UNIT_FRAC_BITS + 1;
  localparam int DIVW = NB + UNIT_FRAC_BITS + 2;
  localparam int PW   = CW + UW;
  localparam int DW   = CW + UW + 2;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] upaxis_x;
    logic signed [15:0] upaxis_y;
    logic signed [15:0] upaxis_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } result_t;

  typedef struct packed {
    logic [2:0][CW-1:0] eye;
    logic [2:0][CW-1:0] up;
    logic [2:0][UW-1:0] back;
    logic [2:0][UW-1:0] right;
  } side_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
    side_t      side;
  } tag_t;

  function automatic logic [15:0] unit_sat(input logic [UW-1:0] v);
    logic signed [UW+16:0] w;
    w = (UW+17)'($signed(v));
    if (w > 32767) return 16'h7fff;
    if (w < -32768) return 16'h8000;
    return w[15:0];
  endfunction

endpackage

// File: rtl/core/lavm_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root, per-component divide.
module lavm_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_vld,
  input  logic [2:0][lavm_pkg::NIW-1:0]  src_vec,
  input  lavm_pkg::side_t                src_side,
  output logic                           res_vld,
  output logic [2:0][lavm_pkg::UW-1:0]   res_vec,
  output lavm_pkg::side_t                res_side
);
  import lavm_pkg::*;

  // stage 1: magnitudes
  logic [2:0][NIW-1:0] mag_c;
  logic [NIW-1:0]      or_c;
  logic                vld1;
  logic [2:0][NIW-1:0] mag1;
  logic [NIW-1:0]      or1;
  logic [2:0]          neg1;
  side_t               side1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = src_vec[i][NIW-1] ? (~src_vec[i] + NIW'(1)) : src_vec[i];
    end
    or_c = mag_c[0] | mag_c[1] | mag_c[2];
  end

  always_ff @(posedge clk) begin
    mag1  <= mag_c;
    or1   <= or_c;
    side1 <= src_side;
    for (int i = 0; i < 3; i++) neg1[i] <= src_vec[i][NIW-1];
  end

  // stage 2: bit length of the largest magnitude
  logic [CNTW-1:0]     bits_c;
  logic                vld2;
  logic [CNTW-1:0]     bits2;
  logic [2:0][NIW-1:0] mag2;
  logic [2:0]          neg2;
  side_t               side2;

  always_comb begin
    bits_c = '0;
    for (int i = 0; i < NIW; i++) begin
      if (or1[i]) bits_c = CNTW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    bits2 <= bits_c;
    mag2  <= mag1;
    neg2  <= neg1;
    side2 <= side1;
  end

  // stage 3: align so the top magnitude sits in [2^29, 2^30)
  logic [2:0][NB-1:0] m_c;
  logic               vld3;
  logic [2:0][NB-1:0] m3;
  tag_t               tag3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bits2 > CNTW'(NB)) m_c[i] = NB'(mag2[i] >> (bits2 - CNTW'(NB)));
      else m_c[i] = NB'(mag2[i] << (CNTW'(NB) - bits2));
    end
  end

  always_ff @(posedge clk) begin
    m3        <= m_c;
    tag3.zero <= (bits2 == '0);
    tag3.neg  <= neg2;
    tag3.side <= side2;
  end

  // stage 4: squares
  logic                   vld4;
  logic [2:0][2*NB-1:0]   sqr4;
  logic [2:0][NB-1:0]     m4;
  tag_t                   tag4;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sqr4[i] <= (2*NB)'(m3[i]) * (2*NB)'(m3[i]);
    m4   <= m3;
    tag4 <= tag3;
  end

  // stage 5 and square root steps
  logic [SQW-1:0]     sx [0:SQ_STEPS];
  logic [SQW-1:0]     sr [0:SQ_STEPS];
  logic [2:0][NB-1:0] sm [0:SQ_STEPS];
  tag_t               st [0:SQ_STEPS];
  logic               sv [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    sx[0] <= SQW'(sqr4[0]) + SQW'(sqr4[1]) + SQW'(sqr4[2]);
    sr[0] <= '0;
    sm[0] <= m4;
    st[0] <= tag4;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQW-1:0] trial;
    assign trial = sr[k] + BIT;
    always_ff @(posedge clk) begin
      if (sx[k] >= trial) begin
        sx[k+1] <= sx[k] - trial;
        sr[k+1] <= (sr[k] >> 1) + BIT;
      end else begin
        sx[k+1] <= sx[k];
        sr[k+1] <= sr[k] >> 1;
      end
      sm[k+1] <= sm[k];
      st[k+1] <= st[k];
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
    end
  end

  // divide steps: q = (m * 2^U + len/2) / len
  logic [LENW-1:0]       len_c;
  logic [2:0][DIVW-1:0]  dr [0:QW];
  logic [2:0][QW-1:0]    dq [0:QW];
  logic [LENW-1:0]       dd [0:QW];
  tag_t                  dt [0:QW];
  logic                  dv [0:QW];

  assign len_c = sr[SQ_STEPS][LENW-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i] <= (DIVW'(sm[SQ_STEPS][i]) << UNIT_FRAC_BITS) + DIVW'(len_c >> 1);
      dq[0][i] <= '0;
    end
    dd[0] <= len_c;
    dt[0] <= st[SQ_STEPS];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [DIVW-1:0] dsh;
    assign dsh = DIVW'(dd[j]) << SH;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dr[j][i] >= dsh) begin
          dr[j+1][i] <= dr[j][i] - dsh;
          dq[j+1][i] <= dq[j][i] | (QW'(1) << SH);
        end else begin
          dr[j+1][i] <= dr[j][i];
          dq[j+1][i] <= dq[j][i];
        end
      end
      dd[j+1] <= dd[j];
      dt[j+1] <= dt[j];
    end
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else dv[j+1] <= dv[j];
    end
  end

  // output: sign restore, zero vector maps to zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dt[QW].zero) res_vec[i] <= '0;
      else if (dt[QW].neg[i]) res_vec[i] <= -UW'(dq[QW][i]);
      else res_vec[i] <= UW'(dq[QW][i]);
    end
    res_side <= dt[QW].side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      sv[0]   <= 1'b0;
      dv[0]   <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      vld1    <= src_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      sv[0]   <= vld4;
      dv[0]   <= sv[SQ_STEPS];
      res_vld <= dv[QW];
    end
  end

endmodule

// File: rtl/core/look_at_view_matrix_core.sv
// Top level: look-at view matrix core, three chained normalizers plus cross and dot stages.
// A request is taken on any cycle with start high (busy is always low); done rises for one
// cycle with the result, in request order, one result per request. Throughput is one
// request per clock. The pipeline holds one input stage, three normalizers of 53 stages
// each (magnitude, bit length, alignment, squares, sum, a 31-step square root, divisor
// load, a 15-step divide, sign restore), two stages per cross product, three dot-product
// stages and the output register.
// The receiver cannot stall, so each result must be captured in its done cycle.
module look_at_view_matrix_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lavm_pkg::cmd_t    cmd,
  output logic              done,
  output lavm_pkg::result_t result
);
  import lavm_pkg::*;

  assign busy = 1'b0;

  // stage A: eye - target
  logic                a_vld;
  logic [2:0][NIW-1:0] a_vec;
  side_t               a_side;

  always_ff @(posedge clk) begin
    a_vec[0] <= NIW'((CW+1)'(cmd.eye_x) - (CW+1)'(cmd.target_x));
    a_vec[1] <= NIW'((CW+1)'(cmd.eye_y) - (CW+1)'(cmd.target_y));
    a_vec[2] <= NIW'((CW+1)'(cmd.eye_z) - (CW+1)'(cmd.target_z));
    a_side.eye   <= {cmd.eye_z, cmd.eye_y, cmd.eye_x};
    a_side.up    <= {cmd.up_z, cmd.up_y, cmd.up_x};
    a_side.back  <= '0;
    a_side.right <= '0;
  end

  logic               n0_vld;
  logic [2:0][UW-1:0] n0_vec;
  side_t              n0_side;

  lavm_norm u_norm_back (
    .clk(clk), .rst(rst),
    .src_vld(a_vld), .src_vec(a_vec), .src_side(a_side),
    .res_vld(n0_vld), .res_vec(n0_vec), .res_side(n0_side)
  );

  // stages B, C: up x back
  logic                b_vld;
  logic signed [PW-1:0] b_p [6];
  side_t               b_side;
  logic                c_vld;
  logic [2:0][NIW-1:0] c_vec;
  side_t               c_side;

  always_ff @(posedge clk) begin
    b_p[0] <= $signed(n0_side.up[1]) * $signed(n0_vec[2]);
    b_p[1] <= $signed(n0_side.up[2]) * $signed(n0_vec[1]);
    b_p[2] <= $signed(n0_side.up[2]) * $signed(n0_vec[0]);
    b_p[3] <= $signed(n0_side.up[0]) * $signed(n0_vec[2]);
    b_p[4] <= $signed(n0_side.up[0]) * $signed(n0_vec[1]);
    b_p[5] <= $signed(n0_side.up[1]) * $signed(n0_vec[0]);
    b_side   <= '{eye: n0_side.eye, up: n0_side.up, back: n0_vec, right: n0_side.right};
    c_vec[0] <= NIW'(b_p[0]) - NIW'(b_p[1]);
    c_vec[1] <= NIW'(b_p[2]) - NIW'(b_p[3]);
    c_vec[2] <= NIW'(b_p[4]) - NIW'(b_p[5]);
    c_side   <= b_side;
  end

  logic               n1_vld;
  logic [2:0][UW-1:0] n1_vec;
  side_t              n1_side;

  lavm_norm u_norm_right (
    .clk(clk), .rst(rst),
    .src_vld(c_vld), .src_vec(c_vec), .src_side(c_side),
    .res_vld(n1_vld), .res_vec(n1_vec), .res_side(n1_side)
  );

  // stages D, E: back x right
  logic                   d_vld;
  logic signed [2*UW-1:0] d_p [6];
  side_t                  d_side;
  logic                   e_vld;
  logic [2:0][NIW-1:0]    e_vec;
  side_t                  e_side;

  always_ff @(posedge clk) begin
    d_p[0] <= $signed(n1_side.back[1]) * $signed(n1_vec[2]);
    d_p[1] <= $signed(n1_side.back[2]) * $signed(n1_vec[1]);
    d_p[2] <= $signed(n1_side.back[2]) * $signed(n1_vec[0]);
    d_p[3] <= $signed(n1_side.back[0]) * $signed(n1_vec[2]);
    d_p[4] <= $signed(n1_side.back[0]) * $signed(n1_vec[1]);
    d_p[5] <= $signed(n1_side.back[1]) * $signed(n1_vec[0]);
    d_side   <= '{eye: n1_side.eye, up: n1_side.up, back: n1_side.back, right: n1_vec};
    e_vec[0] <= NIW'(d_p[0]) - NIW'(d_p[1]);
    e_vec[1] <= NIW'(d_p[2]) - NIW'(d_p[3]);
    e_vec[2] <= NIW'(d_p[4]) - NIW'(d_p[5]);
    e_side   <= d_side;
  end

  logic               n2_vld;
  logic [2:0][UW-1:0] n2_vec;
  side_t              n2_side;

  lavm_norm u_norm_up (
    .clk(clk), .rst(rst),
    .src_vld(e_vld), .src_vec(e_vec), .src_side(e_side),
    .res_vld(n2_vld), .res_vec(n2_vec), .res_side(n2_side)
  );

  // stages F..I: translation terms; axis 0 right, 1 up, 2 back
  logic                    f_vld, g_vld, h_vld;
  logic [2:0][2:0][UW-1:0] f_ax, g_ax, h_ax;
  logic signed [PW-1:0]    f_p [3][3];
  logic signed [DW-1:0]    g_dot [3];
  logic [DW-1:0]           h_mag [3];
  logic [DW-1:0]           h_q [3];
  logic [2:0]              h_neg;
  logic [2:0][31:0]        sh_c;

  always_ff @(posedge clk) begin
    f_ax[0] <= n2_side.right;
    f_ax[1] <= n2_vec;
    f_ax[2] <= n2_side.back;
    for (int i = 0; i < 3; i++) begin
      f_p[0][i] <= $signed(n2_side.right[i]) * $signed(n2_side.eye[i]);
      f_p[1][i] <= $signed(n2_vec[i]) * $signed(n2_side.eye[i]);
      f_p[2][i] <= $signed(n2_side.back[i]) * $signed(n2_side.eye[i]);
    end
    g_ax <= f_ax;
    for (int a = 0; a < 3; a++) begin
      g_dot[a] <= DW'(f_p[a][0]) + DW'(f_p[a][1]) + DW'(f_p[a][2]);
    end
    h_ax <= g_ax;
    for (int a = 0; a < 3; a++) begin
      h_neg[a] <= g_dot[a][DW-1];
      h_q[a]   <= (h_mag[a] + (DW'(1) << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      h_mag[a] = g_dot[a][DW-1] ? DW'(-g_dot[a]) : DW'(g_dot[a]);
      if (h_neg[a]) begin
        sh_c[a] = (h_q[a] > DW'(64'h7fff_ffff)) ? 32'h7fff_ffff : h_q[a][31:0];
      end else begin
        sh_c[a] = (h_q[a] > DW'(64'h8000_0000)) ? 32'h8000_0000 : -h_q[a][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.right_x  <= unit_sat(h_ax[0][0]);
    result.right_y  <= unit_sat(h_ax[0][1]);
    result.right_z  <= unit_sat(h_ax[0][2]);
    result.upaxis_x <= unit_sat(h_ax[1][0]);
    result.upaxis_y <= unit_sat(h_ax[1][1]);
    result.upaxis_z <= unit_sat(h_ax[1][2]);
    result.back_x   <= unit_sat(h_ax[2][0]);
    result.back_y   <= unit_sat(h_ax[2][1]);
    result.back_z   <= unit_sat(h_ax[2][2]);
    result.shift_x  <= sh_c[0];
    result.shift_y  <= sh_c[1];
    result.shift_z  <= sh_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      a_vld <= start;
      b_vld <= n0_vld;
      c_vld <= b_vld;
      d_vld <= n1_vld;
      e_vld <= d_vld;
      f_vld <= n2_vld;
      g_vld <= f_vld;
      h_vld <= g_vld;
      done  <= h_vld;
    end
  end

endmodule

// File: sim/tb_look_at_view_matrix_core.sv
// Testbench: checks the look-at view matrix core against a behavioral predictor.
module tb_look_at_view_matrix_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lavm_pkg::*;

  localparam int UFB = 14;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 400;

  logic clk, rst, start, busy, done;
  cmd_t cmd;
  result_t result;

  result_t view_q[$];
  int errors;
  int idle_cycles;

  look_at_view_matrix_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3], top, sum, len, q;
    int bits;
    top = 0;
    sum = 0;
    bits = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (bits < 64 && (top >> bits) != 0) bits++;
    for (int i = 0; i < 3; i++) begin
      if (bits > 30) m[i] = m[i] >> (bits - 30);
      else m[i] = m[i] << (30 - bits);
      sum = sum + m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << UFB) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [31:0] shift_of(input longint ax[3], input longint e[3]);
    longint d, t;
    longint unsigned q;
    d = ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2];
    q = (mag(d) + (64'd1 << (UFB - 1))) >> UFB;
    t = d < 0 ? longint'(q) : -longint'(q);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic result_t predict_view(cmd_t c);
    longint e[3], u[3], d[3], bk[3], rt[3], ua[3], t[3];
    result_t r;
    e = '{longint'(c.eye_x), longint'(c.eye_y), longint'(c.eye_z)};
    u = '{longint'(c.up_x), longint'(c.up_y), longint'(c.up_z)};
    d[0] = e[0] - longint'(c.target_x);
    d[1] = e[1] - longint'(c.target_y);
    d[2] = e[2] - longint'(c.target_z);
    unit_vec(d, bk);
    cross3(u, bk, t);
    unit_vec(t, rt);
    cross3(bk, rt, t);
    unit_vec(t, ua);
    r.right_x = clamp16(rt[0]); r.right_y = clamp16(rt[1]); r.right_z = clamp16(rt[2]);
    r.upaxis_x = clamp16(ua[0]); r.upaxis_y = clamp16(ua[1]); r.upaxis_z = clamp16(ua[2]);
    r.back_x = clamp16(bk[0]); r.back_y = clamp16(bk[1]); r.back_z = clamp16(bk[2]);
    r.shift_x = shift_of(rt, e);
    r.shift_y = shift_of(ua, e);
    r.shift_z = shift_of(bk, e);
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_request(cmd_t c);
    idle_gap();
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    view_q.push_back(predict_view(c));
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 65536 * 64) - 65536 * 32;
      2: return $urandom_range(0, 255) - 128;
      default: return 32'($signed($urandom_range(0, 2)) - 1) <<< 31 ^ $urandom_range(0, 3);
    endcase
  endfunction

  function automatic cmd_t mk(longint ex, ey, ez, ux, uy, uz, tx, ty, tz);
    cmd_t c;
    c.eye_x = 32'(ex); c.eye_y = 32'(ey); c.eye_z = 32'(ez);
    c.up_x = 32'(ux); c.up_y = 32'(uy); c.up_z = 32'(uz);
    c.target_x = 32'(tx); c.target_y = 32'(ty); c.target_z = 32'(tz);
    return c;
  endfunction

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_request(mk(0, 0, 65536 * 5, 0, 65536, 0, 0, 0, 0));
    send_request(mk(65536, 2, 3, 0, 65536, 0, 65536, 2, 3));
    send_request(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(0, 65536, 0, 0, 65536, 0, 0, 0, 0));
    send_request(mk(0, 65536, 0, 0, -65536, 0, 0, -65536, 0));
    send_request(mk(mx, mx, mx, mx, mn, mx, mn, mn, mn));
    send_request(mk(mn, mn, mn, mn, mx, mn, mx, mx, mx));
    send_request(mk(mx, mn, mx, mn, mn, mn, mn, mx, mn));
    send_request(mk(mx, mx, mx, 1, 0, 0, mn, mn, 0));
    send_request(mk(1, 0, 0, 0, 1, 0, 0, 0, 0));
    send_request(mk(-1, -1, -1, 0, 0, 1, 0, 0, 0));
    send_request(mk(65536, 65536, 65536, 0, 65536, 0, -65536, 0, 65536));
    send_request(mk(mn, 0, 0, 0, 0, mn, mx, 0, 0));
    send_request(mk(-32768, 7, -9, 3, -5, 65536, 12, 99, -4));
    pause_until_drained();
  endtask

  task automatic test_random(int count);
    cmd_t c;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      c = mk(rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
             rand_coord($urandom_range(0, 3)),
             rand_coord(mode), rand_coord(mode), rand_coord(mode));
      case ($urandom_range(0, 9))
        0: begin c.target_x = c.eye_x; c.target_y = c.eye_y; c.target_z = c.eye_z; end
        1: begin c.up_x = c.eye_x - c.target_x; c.up_y = c.eye_y - c.target_y;
                 c.up_z = c.eye_z - c.target_z; end
        2: begin c.up_x = 0; c.up_y = 0; c.up_z = 0; end
        default: ;
      endcase
      send_request(c);
      if (i == count / 2) pause_until_drained();
    end
  endtask

  task automatic test_back_to_back(int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      c = mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom());
      start <= 1'b1;
      cmd <= c;
      @(posedge clk);
      while (busy) @(posedge clk);
      view_q.push_back(predict_view(c));
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (view_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = view_q.pop_front();
        if (result.right_x !== exp_r.right_x) begin
          $error("right_x exp %0d got %0d", exp_r.right_x, result.right_x); errors++; end
        if (result.right_y !== exp_r.right_y) begin
          $error("right_y exp %0d got %0d", exp_r.right_y, result.right_y); errors++; end
        if (result.right_z !== exp_r.right_z) begin
          $error("right_z exp %0d got %0d", exp_r.right_z, result.right_z); errors++; end
        if (result.upaxis_x !== exp_r.upaxis_x) begin
          $error("upaxis_x exp %0d got %0d", exp_r.upaxis_x, result.upaxis_x); errors++; end
        if (result.upaxis_y !== exp_r.upaxis_y) begin
          $error("upaxis_y exp %0d got %0d", exp_r.upaxis_y, result.upaxis_y); errors++; end
        if (result.upaxis_z !== exp_r.upaxis_z) begin
          $error("upaxis_z exp %0d got %0d", exp_r.upaxis_z, result.upaxis_z); errors++; end
        if (result.back_x !== exp_r.back_x) begin
          $error("back_x exp %0d got %0d", exp_r.back_x, result.back_x); errors++; end
        if (result.back_y !== exp_r.back_y) begin
          $error("back_y exp %0d got %0d", exp_r.back_y, result.back_y); errors++; end
        if (result.back_z !== exp_r.back_z) begin
          $error("back_z exp %0d got %0d", exp_r.back_z, result.back_z); errors++; end
        if (result.shift_x !== exp_r.shift_x) begin
          $error("shift_x exp %0d got %0d", exp_r.shift_x, result.shift_x); errors++; end
        if (result.shift_y !== exp_r.shift_y) begin
          $error("shift_y exp %0d got %0d", exp_r.shift_y, result.shift_y); errors++; end
        if (result.shift_z !== exp_r.shift_z) begin
          $error("shift_z exp %0d got %0d", exp_r.shift_z, result.shift_z); errors++; end
      end
    end
  end

  // watchdog: cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_look_at_view_matrix_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1400);
    test_back_to_back(200);
    start <= 1'b0;
    @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && view_q.size() == 0) begin
      $display("tb_look_at_view_matrix_core: done, clean");
    end else begin
      $display("tb_look_at_view_matrix_core: done, errors");
    end
    $finish;
  end
endmodule
